[sv/pinhole_camera_projection_macros.svh]
// assertion macros for the pinhole camera projection rtl
// no dependencies; included by files that carry concurrent checks
`ifndef PINHOLE_CAMERA_PROJECTION_MACROS_SVH
`define PINHOLE_CAMERA_PROJECTION_MACROS_SVH

// same-cycle implication, disabled during reset
`define PCP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcp check failed: same cycle");

// next-cycle implication, disabled during reset
`define PCP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcp check failed: next cycle");

`endif

[sv/pcp_pkg.sv]
// shared codes and types for the pinhole camera projection unit
// no dependencies; imported by every pcp module
package pcp_pkg;

    typedef enum logic
    {
        CMD_PROJECT   = 1'b0,
        CMD_UNPROJECT = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        REG_FOCAL_X  = 2'd0,
        REG_FOCAL_Y  = 2'd1,
        REG_CENTRE_X = 2'd2,
        REG_CENTRE_Y = 2'd3
    } reg_idx_t;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BAD_DEPTH = 1'b1;

    // result lanes, in output field order
    localparam int NUM_LANES = 8;
    localparam int LANE_U    = 0;
    localparam int LANE_V    = 1;
    localparam int LANE_NX   = 2;
    localparam int LANE_NY   = 3;
    localparam int LANE_DUDX = 4;
    localparam int LANE_DVDY = 5;
    localparam int LANE_DUDZ = 6;
    localparam int LANE_DVDZ = 7;

    // sign and nonzero marks of one numerator
    typedef struct packed
    {
        logic neg;
        logic nz;
    } num_flags_t;

endpackage

[sv/pinhole_camera_projection.sv]
// pinhole camera projection, signed fixed point, one result per transfer
// throughput: one item per cycle while the skid entry is empty; three front stages,
//   then eight dividers that each run an overflow check stage and retire one quotient
//   bit per stage, then a saturation stage
// reset clears all valid bits and the skid entry, and loads focal 1.0 and centre 0.5
`include "pinhole_camera_projection_macros.svh"

module pinhole_camera_projection #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic clk,
    input  logic rst_n,
    // input stream
    input  logic s_tvalid,
    output logic s_tready,
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] s_tdata,  // in_x, in_y, in_z
    input  logic s_tuser,                                 // command
    // result stream
    output logic m_tvalid,
    input  logic m_tready,
    // out_u, out_v, norm_x, norm_y, d_u_d_x, d_v_d_y, d_u_d_z, d_v_d_z
    output logic [((8*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
    output logic m_tuser,                                 // status
    // configuration
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [((COORD_WIDTH > 32) ? 5 : 4)-1:0] paddr,
    input  logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0] pwdata,
    output logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0] prdata,
    output logic pready
);
    import pcp_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int FB  = FRAC_BITS;
    localparam int MDW = ((8 * CW + 7) / 8) * 8;
    localparam int AW  = (CW > 32) ? 5 : 4;
    localparam int PDW = (CW > 32) ? 64 : 32;
    // numerator magnitude and divisor widths
    localparam int NW  = 2 * CW + FB + 1;
    localparam int DW  = 2 * CW - 2;
    // three front stages, overflow check, CW quotient bits, saturation
    localparam int NST = CW + 5;
    localparam int DST = CW + 2;

    logic [CW-2:0]        focal_x, focal_y;
    logic signed [CW-1:0] centre_x, centre_y;

    logic [NUM_LANES-1:0][NW-1:0] num_mag;
    num_flags_t [NUM_LANES-1:0]   num_flags;
    logic [NUM_LANES-1:0][DW-1:0] den;
    logic                         front_status;
    logic [NUM_LANES-1:0][CW-1:0] quo;

    logic           en;
    logic [NST-1:0] v_reg;
    logic [DST-1:0] st_reg;
    logic [MDW-1:0] pipe_data;
    logic           skid_v_reg;
    logic [MDW-1:0] skid_data_reg;
    logic           skid_st_reg;

    pcp_cfg #(
        .CW  (CW),
        .FB  (FB),
        .AW  (AW),
        .PDW (PDW)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .focal_x  (focal_x),
        .focal_y  (focal_y),
        .centre_x (centre_x),
        .centre_y (centre_y)
    );

    // whole pipeline moves together; the skid entry absorbs one stalled result
    assign en       = !skid_v_reg;
    assign s_tready = en;

    pcp_front #(
        .CW (CW),
        .FB (FB),
        .NW (NW),
        .DW (DW)
    ) u_front (
        .clk       (clk),
        .en        (en),
        .cmd       (cmd_t'(s_tuser)),
        .in_x      ($signed(s_tdata[CW-1:0])),
        .in_y      ($signed(s_tdata[2*CW-1:CW])),
        .in_z      ($signed(s_tdata[3*CW-1:2*CW])),
        .focal_x   (focal_x),
        .focal_y   (focal_y),
        .centre_x  (centre_x),
        .centre_y  (centre_y),
        .num_mag   (num_mag),
        .num_flags (num_flags),
        .den       (den),
        .status    (front_status)
    );

    // one divider lane per result field
    for (genvar l = 0; l < NUM_LANES; l++)
    begin : g_lane
        pcp_div #(
            .CW (CW),
            .NW (NW),
            .DW (DW)
        ) u_div (
            .clk       (clk),
            .en        (en),
            .num_mag   (num_mag[l]),
            .num_flags (num_flags[l]),
            .den       (den[l]),
            .quo       (quo[l])
        );
    end

    assign pipe_data = MDW'(quo);

    // valid bits march with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NST-2:0], s_tvalid};
        end
    end

    // status rides alongside the divider stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg <= {st_reg[DST-2:0], front_status};
        end
    end

    // skid entry: catches the last stage when the sink stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_v_reg <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            if (m_tready)
                skid_v_reg <= 1'b0;
        end
        else if (v_reg[NST-1] && !m_tready)
        begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_v_reg && v_reg[NST-1] && !m_tready)
        begin
            skid_data_reg <= pipe_data;
            skid_st_reg   <= st_reg[DST-1];
        end
    end

    assign m_tvalid = skid_v_reg || v_reg[NST-1];
    assign m_tdata  = skid_v_reg ? skid_data_reg : pipe_data;
    assign m_tuser  = skid_v_reg ? skid_st_reg : st_reg[DST-1];

    // a held skid result keeps its payload until the sink takes it
    `PCP_ASSERT_NEXT(a_skid_hold, clk, rst_n, skid_v_reg && !m_tready,
                     skid_v_reg && $stable(skid_data_reg))
    // the pipeline freezes while the skid entry is occupied
    `PCP_ASSERT_NEXT(a_pipe_frozen, clk, rst_n, skid_v_reg, $stable(v_reg))
    // a bad-depth result carries all-zero fields
    `PCP_ASSERT_SAME(a_bad_depth_zero, clk, rst_n,
                     v_reg[NST-1] && (st_reg[DST-1] == STATUS_BAD_DEPTH),
                     pipe_data == '0)

endmodule

[sv/pcp_cfg.sv]
// apb register file for focal lengths and principal point
// depends on pcp_pkg
module pcp_cfg #(
    parameter int CW  = 32,
    parameter int FB  = 16,
    parameter int AW  = 4,
    parameter int PDW = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [AW-1:0]       paddr,
    input  logic [PDW-1:0]      pwdata,
    output logic [PDW-1:0]      prdata,
    output logic                pready,
    output logic [CW-2:0]       focal_x,
    output logic [CW-2:0]       focal_y,
    output logic signed [CW-1:0] centre_x,
    output logic signed [CW-1:0] centre_y
);
    import pcp_pkg::*;

    localparam logic [CW-2:0] FOC_RESET = (CW-1)'(1) << FB;
    localparam logic [CW-1:0] CEN_RESET = CW'(1) << (FB - 1);

    logic [CW-2:0] focal_x_reg;
    logic [CW-2:0] focal_y_reg;
    logic [CW-1:0] centre_x_reg;
    logic [CW-1:0] centre_y_reg;
    reg_idx_t      idx;
    logic          wr;

    assign idx    = reg_idx_t'(paddr[AW-1:AW-2]);
    assign wr     = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg  <= FOC_RESET;
            focal_y_reg  <= FOC_RESET;
            centre_x_reg <= CEN_RESET;
            centre_y_reg <= CEN_RESET;
        end
        else if (wr)
        begin
            case (idx)
                REG_FOCAL_X:  focal_x_reg  <= pwdata[CW-2:0];
                REG_FOCAL_Y:  focal_y_reg  <= pwdata[CW-2:0];
                REG_CENTRE_X: centre_x_reg <= pwdata[CW-1:0];
                REG_CENTRE_Y: centre_y_reg <= pwdata[CW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_FOCAL_X:  prdata = PDW'(focal_x_reg);
            REG_FOCAL_Y:  prdata = PDW'(focal_y_reg);
            REG_CENTRE_X: prdata = PDW'(centre_x_reg);
            REG_CENTRE_Y: prdata = PDW'(centre_y_reg);
            default:      prdata = '0;
        endcase
    end

    assign focal_x  = focal_x_reg;
    assign focal_y  = focal_y_reg;
    assign centre_x = $signed(centre_x_reg);
    assign centre_y = $signed(centre_y_reg);

endmodule

[sv/pcp_front.sv]
// front stages: products, signed numerators and divisors, magnitudes
// depends on pcp_pkg
module pcp_front #(
    parameter int CW = 32,
    parameter int FB = 16,
    parameter int NW = 81,
    parameter int DW = 62
) (
    input  logic                 clk,
    input  logic                 en,
    input  pcp_pkg::cmd_t        cmd,
    input  logic signed [CW-1:0] in_x,
    input  logic signed [CW-1:0] in_y,
    input  logic signed [CW-1:0] in_z,
    input  logic [CW-2:0]        focal_x,
    input  logic [CW-2:0]        focal_y,
    input  logic signed [CW-1:0] centre_x,
    input  logic signed [CW-1:0] centre_y,
    output logic [pcp_pkg::NUM_LANES-1:0][NW-1:0] num_mag,
    output pcp_pkg::num_flags_t [pcp_pkg::NUM_LANES-1:0] num_flags,
    output logic [pcp_pkg::NUM_LANES-1:0][DW-1:0] den,
    output logic                 status
);
    import pcp_pkg::*;

    localparam int SW = NW + 1;

    // stage 1: products
    logic signed [2*CW-1:0] fxx_reg, fyy_reg, cxz_reg, cyz_reg, zz_reg;
    logic signed [CW-1:0]   x1_reg, y1_reg, z1_reg;
    cmd_t                   cmd1_reg;
    logic                   bad1_reg;

    // stage 2: signed numerators and divisors
    logic signed [SW-1:0]   n_next [NUM_LANES];
    logic [DW-1:0]          d_next [NUM_LANES];
    logic signed [SW-1:0]   n2_reg [NUM_LANES];
    logic [DW-1:0]          d2_reg [NUM_LANES];
    logic                   bad2_reg;

    // stage 3: magnitudes
    logic [NUM_LANES-1:0][NW-1:0] mag_reg;
    num_flags_t [NUM_LANES-1:0]   flags_reg;
    logic [NUM_LANES-1:0][DW-1:0] den_reg;
    logic                         bad3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fxx_reg  <= $signed({1'b0, focal_x}) * in_x;
            fyy_reg  <= $signed({1'b0, focal_y}) * in_y;
            cxz_reg  <= centre_x * in_z;
            cyz_reg  <= centre_y * in_z;
            zz_reg   <= in_z * in_z;
            x1_reg   <= in_x;
            y1_reg   <= in_y;
            z1_reg   <= in_z;
            cmd1_reg <= cmd;
            // depth must be strictly positive
            bad1_reg <= (cmd == CMD_PROJECT) && (in_z[CW-1] || (in_z == '0));
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            n_next[i] = '0;
            d_next[i] = '0;
        end
        case (cmd1_reg)
            CMD_PROJECT:
            begin
                if (!bad1_reg)
                begin
                    n_next[LANE_U]    = SW'(fxx_reg) + SW'(cxz_reg);
                    n_next[LANE_V]    = SW'(fyy_reg) + SW'(cyz_reg);
                    n_next[LANE_NX]   = SW'(x1_reg) <<< FB;
                    n_next[LANE_NY]   = SW'(y1_reg) <<< FB;
                    n_next[LANE_DUDX] = SW'({1'b0, focal_x}) <<< FB;
                    n_next[LANE_DVDY] = SW'({1'b0, focal_y}) <<< FB;
                    n_next[LANE_DUDZ] = -(SW'(fxx_reg) <<< FB);
                    n_next[LANE_DVDZ] = -(SW'(fyy_reg) <<< FB);
                end
                for (int i = LANE_U; i <= LANE_DVDY; i++)
                begin
                    d_next[i] = DW'($unsigned(z1_reg));
                end
                d_next[LANE_DUDZ] = zz_reg[DW-1:0];
                d_next[LANE_DVDZ] = zz_reg[DW-1:0];
            end
            CMD_UNPROJECT:
            begin
                n_next[LANE_U]    = (SW'(x1_reg) - SW'(centre_x)) <<< FB;
                n_next[LANE_V]    = (SW'(y1_reg) - SW'(centre_y)) <<< FB;
                n_next[LANE_DUDX] = SW'(1) <<< (2 * FB);
                n_next[LANE_DVDY] = SW'(1) <<< (2 * FB);
                d_next[LANE_U]    = DW'(focal_x);
                d_next[LANE_V]    = DW'(focal_y);
                d_next[LANE_DUDX] = DW'(focal_x);
                d_next[LANE_DVDY] = DW'(focal_y);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NUM_LANES; i++)
            begin
                n2_reg[i] <= n_next[i];
                d2_reg[i] <= d_next[i];
            end
            bad2_reg <= bad1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NUM_LANES; i++)
            begin
                mag_reg[i]       <= n2_reg[i][SW-1] ? NW'(-n2_reg[i]) : NW'(n2_reg[i]);
                flags_reg[i].neg <= n2_reg[i][SW-1];
                flags_reg[i].nz  <= (n2_reg[i] != '0);
                den_reg[i]       <= d2_reg[i];
            end
            bad3_reg <= bad2_reg;
        end
    end

    assign num_mag   = mag_reg;
    assign num_flags = flags_reg;
    assign den       = den_reg;
    assign status    = bad3_reg ? STATUS_BAD_DEPTH : STATUS_OK;

endmodule

[sv/pcp_div.sv]
// pipelined restoring divider, one quotient bit per stage, with saturation
// depends on pcp_pkg
module pcp_div #(
    parameter int CW = 32,
    parameter int NW = 81,
    parameter int DW = 62
) (
    input  logic                clk,
    input  logic                en,
    input  logic [NW-1:0]       num_mag,
    input  pcp_pkg::num_flags_t num_flags,
    input  logic [DW-1:0]       den,
    output logic [CW-1:0]       quo
);
    import pcp_pkg::*;

    localparam int RW = (NW > DW + CW) ? NW : DW + CW;

    logic [RW-1:0]  rem_reg [0:CW-1];
    logic [DW-1:0]  den_reg [0:CW-1];
    logic [CW-1:0]  q_reg   [0:CW];
    logic           big_reg [0:CW];
    num_flags_t     fl_reg  [0:CW];
    logic [CW-1:0]  quo_reg;
    logic [CW-1:0]  quo_next;

    // quotient of 2^CW or more (or a zero divisor under a nonzero numerator) saturates
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= RW'(num_mag);
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            big_reg[0] <= RW'(num_mag) >= (RW'(den) << CW);
            fl_reg[0]  <= num_flags;
        end
    end

    for (genvar k = 1; k <= CW; k++)
    begin : g_step
        localparam int B = CW - k;
        logic [RW:0] diff;

        assign diff = {1'b0, rem_reg[k-1]} - {1'b0, (RW'(den_reg[k-1]) << B)};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[k]   <= {q_reg[k-1][CW-2:0], !diff[RW]};
                big_reg[k] <= big_reg[k-1];
                fl_reg[k]  <= fl_reg[k-1];
            end
        end

        if (k < CW)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= diff[RW] ? rem_reg[k-1] : diff[RW-1:0];
                    den_reg[k] <= den_reg[k-1];
                end
            end
        end
    end

    always_comb
    begin
        if (!fl_reg[CW].nz)
        begin
            quo_next = '0;
        end
        else if (fl_reg[CW].neg)
        begin
            if (big_reg[CW] || (q_reg[CW][CW-1] && (|q_reg[CW][CW-2:0])))
                quo_next = {1'b1, {(CW-1){1'b0}}};
            else
                quo_next = -q_reg[CW];
        end
        else
        begin
            if (big_reg[CW] || q_reg[CW][CW-1])
                quo_next = {1'b0, {(CW-1){1'b1}}};
            else
                quo_next = q_reg[CW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg <= quo_next;
        end
    end

    assign quo = quo_reg;

endmodule

[dv/testbench.sv]
// self-checking testbench for the pinhole camera projection unit
// depends on pcp_pkg and pinhole_camera_projection; predicts every untyped result
// with wide signed integer math and compares it field by field
`timescale 1ns / 100ps

module testbench;
    import pcp_pkg::*;

    localparam int W         = 32;
    localparam int FOCAL_W   = W - 1;
    localparam int LATENCY   = W + 5;
    localparam int WD_LIMIT  = 20000;
    localparam int N_RANDOM  = 1600;

    typedef logic signed [127:0] wide_t;

    // one result transfer
    typedef struct
    {
        logic           status;
        logic [W-1:0]   lane [NUM_LANES];
    } pixel_result_t;

    // one directed row; typed rows carry their expected status with all lanes zero
    typedef struct
    {
        cmd_t           cmd;
        logic [W-1:0]   x;
        logic [W-1:0]   y;
        logic [W-1:0]   z;
        bit             typed;
        logic           status;
    } probe_row_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [3*W-1:0] s_tdata;   // in_x, in_y, in_z
    logic s_tuser;             // command
    logic m_tvalid;
    logic m_tready;
    logic [8*W-1:0] m_tdata;   // out_u, out_v, norm_x, norm_y, d_u_d_x, d_v_d_y, d_u_d_z, d_v_d_z
    logic m_tuser;             // status
    logic psel;
    logic penable;
    logic pwrite;
    logic [3:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    // predictor copy of the camera registers
    logic [FOCAL_W-1:0] cam_fx;
    logic [FOCAL_W-1:0] cam_fy;
    logic [W-1:0]       cam_cx;
    logic [W-1:0]       cam_cy;

    pixel_result_t pending_results[$];
    int  mismatches;
    int  results_seen;
    int  bad_depth_seen;
    int  unproject_seen;
    int  idle_cycles;
    int  burst_left;

    pinhole_camera_projection i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 clk = ~clk;

    // quotient rounded toward zero, saturated to the signed output range;
    // a zero divisor saturates toward the sign of the numerator
    function automatic logic [W-1:0] div_sat(input wide_t num, input wide_t den);
        wide_t q;
        wide_t hi;
        wide_t lo;
        hi = (wide_t'(1) <<< (W - 1)) - 1;
        lo = -(wide_t'(1) <<< (W - 1));
        if (num == 0)
            return '0;
        if (den == 0)
            return (num < 0) ? lo[W-1:0] : hi[W-1:0];
        q = num / den;
        if (q > hi)
            q = hi;
        if (q < lo)
            q = lo;
        return q[W-1:0];
    endfunction

    function automatic pixel_result_t project_point(input cmd_t cmd, input logic [W-1:0] px,
                                                    input logic [W-1:0] py,
                                                    input logic [W-1:0] pz);
        pixel_result_t r;
        wide_t x, y, z, fx, fy, cx, cy, one, fxx, fyy;
        x   = $signed(px);
        y   = $signed(py);
        z   = $signed(pz);
        cx  = $signed(cam_cx);
        cy  = $signed(cam_cy);
        fx  = {97'b0, cam_fx};
        fy  = {97'b0, cam_fy};
        one = wide_t'(1) <<< 16;
        r.status = STATUS_OK;
        foreach (r.lane[i])
            r.lane[i] = '0;
        if (cmd == CMD_PROJECT)
        begin
            // depth at or behind the camera gives an empty invalid result
            if (z <= 0)
            begin
                r.status = STATUS_BAD_DEPTH;
                return r;
            end
            fxx = fx * x;
            fyy = fy * y;
            r.lane[LANE_U]    = div_sat(fxx + cx * z, z);
            r.lane[LANE_V]    = div_sat(fyy + cy * z, z);
            r.lane[LANE_NX]   = div_sat(x * one, z);
            r.lane[LANE_NY]   = div_sat(y * one, z);
            r.lane[LANE_DUDX] = div_sat(fx * one, z);
            r.lane[LANE_DVDY] = div_sat(fy * one, z);
            r.lane[LANE_DUDZ] = div_sat(-(fxx * one), z * z);
            r.lane[LANE_DVDZ] = div_sat(-(fyy * one), z * z);
        end
        else
        begin
            r.lane[LANE_U]    = div_sat((x - cx) * one, fx);
            r.lane[LANE_V]    = div_sat((y - cy) * one, fy);
            r.lane[LANE_DUDX] = div_sat(one * one, fx);
            r.lane[LANE_DVDY] = div_sat(one * one, fy);
        end
        return r;
    endfunction

    // coordinate with a mix of shapes: full range, small, near one, extremes
    function automatic logic [W-1:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return W'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
            2: return W'($signed($urandom_range(0, 'h7ffff)) - 'h40000);
            3: return {1'b0, 31'($urandom)} >> $urandom_range(0, 30);
            4: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return $urandom_range(0, 3) - 1;
        endcase
    endfunction

    // apb write: setup cycle then access cycle, driven on falling edges
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_FOCAL_X:  cam_fx = value[FOCAL_W-1:0];
            REG_FOCAL_Y:  cam_fy = value[FOCAL_W-1:0];
            REG_CENTRE_X: cam_cx = value;
            REG_CENTRE_Y: cam_cy = value;
            default:
            begin
            end
        endcase
    endtask

    task automatic set_camera(input logic [31:0] fx, input logic [31:0] fy,
                              input logic [31:0] cx, input logic [31:0] cy);
        write_reg(REG_FOCAL_X, fx);
        write_reg(REG_FOCAL_Y, fy);
        write_reg(REG_CENTRE_X, cx);
        write_reg(REG_CENTRE_Y, cy);
    endtask

    // hold off until the pipeline has drained before touching registers
    task automatic drain();
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 8) @(negedge clk);
    endtask

    // one input transfer; caller is at a falling edge, returns at a falling edge
    task automatic send_point(input cmd_t cmd, input logic [W-1:0] x, input logic [W-1:0] y,
                              input logic [W-1:0] z, input bit typed, input logic status);
        pixel_result_t exp_r;
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {z, y, x};
        if (typed)
        begin
            exp_r.status = status;
            foreach (exp_r.lane[i])
                exp_r.lane[i] = '0;
        end
        else
            exp_r = project_point(cmd, x, y, z);
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(exp_r);
        @(negedge clk);
    endtask

    task automatic end_stream();
        s_tvalid <= 1'b0;
        @(negedge clk);
    endtask

    // receiver stall pattern: alternating runs of ready and stall of random length
    initial
    begin
        int run;
        m_tready = 1'b0;
        forever
        begin
            run = $urandom_range(1, 30);
            repeat (run)
            begin
                @(negedge clk);
                m_tready <= 1'b1;
            end
            run = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (run)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        pixel_result_t exp_r;
        logic [W-1:0] got;
        bit bad;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (m_tuser == STATUS_BAD_DEPTH)
                bad_depth_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer at %0t", $time);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                bad = (m_tuser !== exp_r.status);
                for (int i = 0; i < NUM_LANES; i++)
                begin
                    got = m_tdata[i*W +: W];
                    if (got !== exp_r.lane[i])
                        bad = 1'b1;
                end
                if (bad)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch at %0t: status exp %0d got %0d",
                                 $time, exp_r.status, m_tuser);
                        for (int i = 0; i < NUM_LANES; i++)
                            $display("  lane %0d exp %h got %h",
                                     i, exp_r.lane[i], m_tdata[i*W +: W]);
                    end
                end
            end
        end
    end

    // watchdog: cycles with work outstanding but no transfer anywhere
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cycles <= 0;
        else if (s_tvalid || pending_results.size() != 0)
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WD_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // directed points, run with the reset camera (focal 1.0, centre 0.5)
    probe_row_t probes[] = '{
        '{CMD_PROJECT,   32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 1'b0, STATUS_OK},
        // zero depth, negative depth and most negative depth are invalid
        '{CMD_PROJECT,   32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 1'b1, STATUS_BAD_DEPTH},
        '{CMD_PROJECT,   32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 1'b1, STATUS_BAD_DEPTH},
        '{CMD_PROJECT,   32'h1234_5678, 32'h0000_0001, 32'h8000_0000, 1'b1, STATUS_BAD_DEPTH},
        // smallest positive depth is valid and saturates hard
        '{CMD_PROJECT,   32'h0000_0001, 32'hffff_ffff, 32'h0000_0001, 1'b0, STATUS_OK},
        '{CMD_PROJECT,   32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 1'b0, STATUS_OK},
        '{CMD_PROJECT,   32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0, STATUS_OK},
        '{CMD_PROJECT,   32'h0000_0000, 32'h0000_0000, 32'h7fff_ffff, 1'b0, STATUS_OK},
        '{CMD_PROJECT,   32'hffff_0000, 32'h0003_8000, 32'h0004_0000, 1'b0, STATUS_OK},
        // unproject ignores depth
        '{CMD_UNPROJECT, 32'h0000_8000, 32'h0000_8000, 32'h0000_0000, 1'b0, STATUS_OK},
        '{CMD_UNPROJECT, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 1'b0, STATUS_OK},
        '{CMD_UNPROJECT, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b0, STATUS_OK},
        '{CMD_UNPROJECT, 32'h0005_0000, 32'hfffb_0000, 32'h1234_5678, 1'b0, STATUS_OK}
    };

    initial
    begin
        logic [W-1:0] x, y, z;
        cmd_t cmd;
        clk            = 1'b0;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = CMD_PROJECT;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        mismatches     = 0;
        results_seen   = 0;
        bad_depth_seen = 0;
        unproject_seen = 0;
        idle_cycles    = 0;
        burst_left     = 0;
        cam_fx         = 31'h0001_0000;
        cam_fy         = 31'h0001_0000;
        cam_cx         = 32'h0000_8000;
        cam_cy         = 32'h0000_8000;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (probes[i])
        begin
            send_point(probes[i].cmd, probes[i].x, probes[i].y, probes[i].z,
                       probes[i].typed, probes[i].status);
            if (probes[i].cmd == CMD_UNPROJECT)
                unproject_seen++;
        end
        end_stream();

        // camera settings per phase: extremes first, then the reset camera again, then random ones
        for (int phase = 0; phase < 8; phase++)
        begin
            drain();
            case (phase)
                0: set_camera(32'h0000_0001, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
                1: set_camera(32'h7fff_ffff, 32'h0000_0001, 32'h7fff_ffff, 32'h8000_0000);
                // top bit of the focal write is dropped
                2: set_camera(32'h8002_0000, 32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff);
                3: set_camera(32'h0001_0000, 32'h0001_0000, 32'h0000_8000, 32'h0000_8000);
                default: set_camera($urandom_range(1, 'h7fff_ffff) >> $urandom_range(0, 14),
                                    $urandom_range(1, 'h7fff_ffff) >> $urandom_range(0, 14),
                                    $urandom, $urandom);
            endcase
            for (int n = 0; n < N_RANDOM / 8; n++)
            begin
                cmd = ($urandom_range(0, 3) == 0) ? CMD_UNPROJECT : CMD_PROJECT;
                x = pick_coord();
                y = pick_coord();
                // mostly positive depths so projections get past the depth check
                z = ($urandom_range(0, 7) == 0) ? pick_coord()
                                                : ({1'b0, 31'($urandom)} >> $urandom_range(0, 30));
                if (cmd == CMD_UNPROJECT)
                    unproject_seen++;
                send_point(cmd, x, y, z, 1'b0, STATUS_OK);
            end
            end_stream();
        end

        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 8) @(negedge clk);
        if (m_tvalid)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("extra result transfer after drain");
        end

        $display("covered %0d results (%0d invalid depth, %0d unprojections) over 9 camera settings",
                 results_seen, bad_depth_seen, unproject_seen);
        $display("with sender bursts, receiver stalls and %0d mismatches", mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[pinhole_camera_projection.f]
+incdir+sv
sv/pcp_pkg.sv
sv/pcp_cfg.sv
sv/pcp_front.sv
sv/pcp_div.sv
sv/pinhole_camera_projection.sv
dv/testbench.sv
